// File: rtl/core/flr_pkg.sv
// Shared types, constants and decode functions of the framelet line router.
// Used by every module in rtl/core; depends on nothing else.
package flr_pkg;

   // Field widths.
   localparam int OUT_LINE_W = 22;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 20;
   localparam int CUBE_W     = 20;
   localparam int SAMPLES_W  = 13;
   localparam int START_W    = 12;
   localparam int OFFSET_W   = 6;
   localparam int REM_W      = 7;
   localparam int COEFF_W    = 6;
   localparam int PAD_W      = 12;
   localparam int OFF_W      = 5;

   // Instrument modes.
   typedef enum logic [1:0] {
      MODE_COLOR = 2'd0,
      MODE_VIS   = 2'd1,
      MODE_UV    = 2'd2,
      MODE_BW    = 2'd3
   } mode_type;

   // Register indexes of the configuration port.
   localparam logic [CSR_ADDR_W-1:0] CSR_MODE          = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_COLOR_OFFSET  = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_FLIP_LINES    = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_UV_CUBE_LINES = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_VIS_CUBE_LINES = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_INPUT_SAMPLES = 3'd5;

   // Framelet set sizes in lines.
   localparam logic [REM_W-1:0] SET_COLOR = 7'd78;
   localparam logic [REM_W-1:0] SET_VIS   = 7'd70;
   localparam logic [REM_W-1:0] SET_UV    = 7'd8;
   localparam logic [REM_W-1:0] SET_BW    = 7'd14;

   // Framelet heights.
   localparam logic [3:0] UV_HEIGHT  = 4'd4;
   localparam logic [3:0] VIS_HEIGHT = 4'd14;

   // Centered ultraviolet window.
   localparam logic [SAMPLES_W-1:0] UV_WINDOW    = 13'd128;
   localparam logic [START_W-1:0]   UV_HALF_SPAN = 12'd64;

   // Reset values of the wide registers.
   localparam logic [CUBE_W-1:0]    CUBE_LINES_RESET    = 20'd1;
   localparam logic [SAMPLES_W-1:0] INPUT_SAMPLES_RESET = 13'd1024;

   // Destination codes.
   localparam logic [1:0] DEST_UV_EVEN  = 2'd0;
   localparam logic [1:0] DEST_VIS_EVEN = 2'd2;

   // Quotient and remainder of the set division.
   typedef struct packed {
      logic [OUT_LINE_W-1:0] set_low;
      logic [REM_W-1:0]      rem;
      logic                  zero;
   } div_type;

   // Framelet position and band decode.
   typedef struct packed {
      logic [OUT_LINE_W-1:0]   set_low;
      logic                    uv;
      logic [1:0]              dest;
      logic [2:0]              band;
      logic signed [OFF_W-1:0] line_off;
      logic [COEFF_W-1:0]      coeff;
   } loc_type;

   // Finished routing result.
   typedef struct packed {
      logic [1:0]            dest;
      logic [2:0]            band;
      logic [OUT_LINE_W-1:0] out_line;
      logic                  extract;
      logic [START_W-1:0]    start;
      logic                  err;
   } res_type;

   // Lines per framelet set for a mode.
   function automatic logic [REM_W-1:0] set_size(input mode_type m);
      logic [REM_W-1:0] s;
      case (m)
         MODE_COLOR: s = SET_COLOR;
         MODE_VIS:   s = SET_VIS;
         MODE_UV:    s = SET_UV;
         MODE_BW:    s = SET_BW;
         default:    s = SET_COLOR;
      endcase
      return s;
   endfunction

   // Height of framelet k in a set; zero past the last framelet in every mode but color.
   function automatic logic [3:0] fl_height(input mode_type m, input logic [2:0] k);
      logic [3:0] h;
      case (m)
         MODE_COLOR: h = (k < 3'd2) ? UV_HEIGHT : VIS_HEIGHT;
         MODE_VIS:   h = (k < 3'd5) ? VIS_HEIGHT : 4'd0;
         MODE_UV:    h = (k < 3'd2) ? UV_HEIGHT : 4'd0;
         MODE_BW:    h = (k == 3'd0) ? VIS_HEIGHT : 4'd0;
         default:    h = 4'd0;
      endcase
      return h;
   endfunction

   // Finds the framelet holding a set offset and derives band and stream.
   function automatic loc_type frame_locate(input mode_type m, input div_type d);
      loc_type          res;
      logic [REM_W-1:0] first;
      logic [3:0]       h;
      logic             found;
      logic [2:0]       fr;
      logic [REM_W-1:0] off;
      logic [2:0]       band_idx;
      first = '0;
      found = 1'b0;
      fr    = '0;
      off   = '0;
      // Walk the framelets of the set, seven at most.
      for (int k = 0; k < 7; k++) begin
         h = fl_height(m, 3'(k));
         if (!found && (d.rem < first + REM_W'(h))) begin
            found = 1'b1;
            fr    = 3'(k);
            off   = d.rem - first;
         end
         first = first + REM_W'(h);
      end
      h = fl_height(m, fr);
      res.set_low = d.set_low;
      res.uv      = (m == MODE_UV) || ((m == MODE_COLOR) && (fr < 3'd2));
      // Color mode numbers the visible bands from one again.
      res.band    = ((m == MODE_COLOR) && (fr >= 3'd2)) ? fr - 3'd1 : fr + 3'd1;
      band_idx    = res.band - 3'd1;
      res.coeff   = COEFF_W'(h) * COEFF_W'(band_idx);
      // Odd-numbered sets go to the even streams.
      res.dest    = (res.uv ? DEST_UV_EVEN : DEST_VIS_EVEN) | {1'b0, ~d.set_low[0]};
      // Line zero sits one line before the first framelet.
      res.line_off = d.zero ? {OFF_W{1'b1}} : OFF_W'(off);
      return res;
   endfunction

endpackage

// File: rtl/core/framelet_line_router_unit.sv
// Top level of the framelet line router: configuration registers and pipeline.
// Depends on flr_pkg, flr_divide, flr_locate and flr_place.
//
//   Channel  Direction  Payload
//   req_     in         tdata: line_number
//   rsp_     out        tdata: out_band, out_line, start_sample; tuser: destination,
//                       extract_middle, error
//   csr_     in         write enable, register index, write data
//
// One line enters per cycle while the results are taken; its result passes through four division
// stages, one framelet search stage and three placement stages.
// Reset is synchronous and clears all stage valid bits and the configuration registers.
// A stalled result holds in the output stage; earlier stages keep filling any
// empty slot, so req_tready drops only once every stage holds a transaction.
module framelet_line_router_unit #(
   parameter int LINE_BITS = 20
) (
   input  logic                                clock,
   input  logic                                reset,
   // Input transactions.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // Bits from 0: line_number.
   input  logic [((LINE_BITS+7)/8)*8-1:0]      req_tdata,
   // Result transactions.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // Bits from 0: out_band [2:0], out_line [24:3], start_sample [36:25], zeros.
   output logic [39:0]                         rsp_tdata,
   // Bits from 0: destination [1:0], extract_middle [2], error [3].
   output logic [3:0]                          rsp_tuser,
   // Register writes.
   input  logic                                csr_wen,
   input  logic [flr_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [flr_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import flr_pkg::*;

   mode_type               mode_ff;
   logic [OFFSET_W-1:0]    color_offset_ff;
   logic                   flip_lines_ff;
   logic [CUBE_W-1:0]      uv_cube_lines_ff;
   logic [CUBE_W-1:0]      vis_cube_lines_ff;
   logic [SAMPLES_W-1:0]   input_samples_ff;

   logic                   div_valid, div_ready;
   div_type                div_data;
   logic                   loc_valid, loc_ready;
   loc_type                loc_data;
   res_type                res;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff           <= MODE_COLOR;
         color_offset_ff   <= '0;
         flip_lines_ff     <= 1'b0;
         uv_cube_lines_ff  <= CUBE_LINES_RESET;
         vis_cube_lines_ff <= CUBE_LINES_RESET;
         input_samples_ff  <= INPUT_SAMPLES_RESET;
      end else if (csr_wen) begin
         case (csr_addr)
            CSR_MODE:           mode_ff           <= mode_type'(csr_wdata[1:0]);
            CSR_COLOR_OFFSET:   color_offset_ff   <= csr_wdata[OFFSET_W-1:0];
            CSR_FLIP_LINES:     flip_lines_ff     <= csr_wdata[0];
            CSR_UV_CUBE_LINES:  uv_cube_lines_ff  <= csr_wdata[CUBE_W-1:0];
            CSR_VIS_CUBE_LINES: vis_cube_lines_ff <= csr_wdata[CUBE_W-1:0];
            CSR_INPUT_SAMPLES:  input_samples_ff  <= csr_wdata[SAMPLES_W-1:0];
            default: ;
         endcase
      end
   end

   // Set number and offset within the set.
   flr_divide #(
      .LINE_BITS (LINE_BITS)
   ) u_divide (
      .clock       (clock),
      .reset       (reset),
      .mode        (mode_ff),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .line_number (req_tdata[LINE_BITS-1:0]),
      .out_valid   (div_valid),
      .out_ready   (div_ready),
      .out_data    (div_data)
   );

   // Framelet, band and stream.
   flr_locate u_locate (
      .clock     (clock),
      .reset     (reset),
      .mode      (mode_ff),
      .in_valid  (div_valid),
      .in_ready  (div_ready),
      .in_data   (div_data),
      .out_valid (loc_valid),
      .out_ready (loc_ready),
      .out_data  (loc_data)
   );

   // Output line, flip and UV window.
   flr_place u_place (
      .clock          (clock),
      .reset          (reset),
      .color_offset   (color_offset_ff),
      .flip_lines     (flip_lines_ff),
      .uv_cube_lines  (uv_cube_lines_ff),
      .vis_cube_lines (vis_cube_lines_ff),
      .input_samples  (input_samples_ff),
      .in_valid       (loc_valid),
      .in_ready       (loc_ready),
      .in_data        (loc_data),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .out_data       (res)
   );

   // Result packing.
   assign rsp_tdata = {3'b000, res.start, res.out_line, res.band};
   assign rsp_tuser = {res.err, res.extract, res.dest};

endmodule

// File: rtl/core/flr_divide.sv
// Four-stage division of the zero-based line number by the set size.
// Depends on flr_pkg for the mode type, set sizes and the result struct.
module flr_divide #(
   parameter int LINE_BITS = 20
) (
   input  logic                  clock,
   input  logic                  reset,
   input  flr_pkg::mode_type     mode,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [LINE_BITS-1:0]  line_number,
   output logic                  out_valid,
   input  logic                  out_ready,
   output flr_pkg::div_type      out_data
);
   import flr_pkg::*;

   localparam int NS    = 4;
   localparam int MUL_W = LINE_BITS - 2;
   localparam longint unsigned SCALE = 64'd1 << LINE_BITS;
   localparam logic [MUL_W-1:0] RECIP_COLOR = MUL_W'(SCALE / SET_COLOR);
   localparam logic [MUL_W-1:0] RECIP_VIS   = MUL_W'(SCALE / SET_VIS);
   localparam logic [MUL_W-1:0] RECIP_UV    = MUL_W'(SCALE / SET_UV);
   localparam logic [MUL_W-1:0] RECIP_BW    = MUL_W'(SCALE / SET_BW);

   logic [NS-1:0]              vld_ff;
   logic [NS:0]                adv;
   logic [MUL_W-1:0]           recip;
   logic [REM_W-1:0]           divisor;
   logic [LINE_BITS-1:0]       x1_in, x1_ff, x2_ff;
   logic                       zero1_ff, zero2_ff, zero3_ff, zero4_ff;
   logic [LINE_BITS+MUL_W-1:0] prod;
   logic [LINE_BITS-1:0]       q2_ff, q3_ff, q4_in, q4_ff;
   logic [LINE_BITS-1:0]       qd;
   logic [LINE_BITS-1:0]       diff;
   logic [REM_W:0]             r3_ff;
   logic [REM_W-1:0]           r4_in, r4_ff;
   logic [LINE_BITS+OUT_LINE_W-1:0] q_wide;

   // Stage handshake: a stage moves when it is empty or its successor moves.
   assign adv[NS] = out_ready;
   for (genvar k = 0; k < NS; k++) begin : g_adv
      assign adv[k] = ~vld_ff[k] | adv[k+1];
   end
   assign in_ready  = adv[0];
   assign out_valid = vld_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) begin
            vld_ff[0] <= in_valid;
         end
         for (int k = 1; k < NS; k++) begin
            if (adv[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   // Reciprocal and divisor of the current mode.
   always_comb begin
      case (mode)
         MODE_COLOR: recip = RECIP_COLOR;
         MODE_VIS:   recip = RECIP_VIS;
         MODE_UV:    recip = RECIP_UV;
         MODE_BW:    recip = RECIP_BW;
         default:    recip = RECIP_COLOR;
      endcase
   end
   assign divisor = set_size(mode);

   // Stage one: make the line number zero-based; line zero divides as zero.
   assign x1_in = (line_number == '0) ? '0 : line_number - LINE_BITS'(1);

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         x1_ff    <= x1_in;
         zero1_ff <= (line_number == '0);
      end
   end

   // Stage two: estimated quotient, low by at most one.
   assign prod = {{MUL_W{1'b0}}, x1_ff} * {{LINE_BITS{1'b0}}, recip};

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         q2_ff    <= prod[LINE_BITS+MUL_W-1:MUL_W] >> (LINE_BITS - MUL_W);
         x2_ff    <= x1_ff;
         zero2_ff <= zero1_ff;
      end
   end

   // Stage three: partial remainder, below twice the divisor.
   assign qd   = q2_ff * LINE_BITS'(divisor);
   assign diff = x2_ff - qd;

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         r3_ff    <= diff[REM_W:0];
         q3_ff    <= q2_ff;
         zero3_ff <= zero2_ff;
      end
   end

   // Stage four: one correction step.
   always_comb begin
      if (r3_ff >= {1'b0, divisor}) begin
         q4_in = q3_ff + LINE_BITS'(1);
         r4_in = REM_W'(r3_ff - {1'b0, divisor});
      end else begin
         q4_in = q3_ff;
         r4_in = r3_ff[REM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         q4_ff    <= q4_in;
         r4_ff    <= r4_in;
         zero4_ff <= zero3_ff;
      end
   end

   // The set number is zero-extended and cut to the output line width.
   assign q_wide           = {{OUT_LINE_W{1'b0}}, q4_ff};
   assign out_data.set_low = q_wide[OUT_LINE_W-1:0];
   assign out_data.rem     = r4_ff;
   assign out_data.zero    = zero4_ff;

endmodule

// File: rtl/core/flr_locate.sv
// One-stage framelet search, band decode and stream selection.
// Depends on flr_pkg for frame_locate and the stage structs.
module flr_locate (
   input  logic              clock,
   input  logic              reset,
   input  flr_pkg::mode_type mode,
   input  logic              in_valid,
   output logic              in_ready,
   input  flr_pkg::div_type  in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output flr_pkg::loc_type  out_data
);
   import flr_pkg::*;

   logic    vld_ff;
   logic    adv;
   loc_type loc_in, loc_ff;

   // The stage moves when empty or when the next one takes its transaction.
   assign adv       = ~vld_ff | out_ready;
   assign in_ready  = adv;
   assign out_valid = vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= in_valid;
      end
   end

   // Framelet, band, stream and padding factor.
   assign loc_in = frame_locate(mode, in_data);

   always_ff @(posedge clock) begin
      if (adv) begin
         loc_ff <= loc_in;
      end
   end

   assign out_data = loc_ff;

endmodule

// File: rtl/core/flr_place.sv
// Three-stage output line placement with padding, flip and UV window.
// Depends on flr_pkg for the stage structs and window constants.
module flr_place (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [flr_pkg::OFFSET_W-1:0]        color_offset,
   input  logic                                flip_lines,
   input  logic [flr_pkg::CUBE_W-1:0]          uv_cube_lines,
   input  logic [flr_pkg::CUBE_W-1:0]          vis_cube_lines,
   input  logic [flr_pkg::SAMPLES_W-1:0]       input_samples,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  flr_pkg::loc_type                    in_data,
   output logic                                out_valid,
   input  logic                                out_ready,
   output flr_pkg::res_type                    out_data
);
   import flr_pkg::*;

   localparam int NS = 3;

   logic [NS-1:0]           vld_ff;
   logic [NS:0]             adv;
   logic [OUT_LINE_W-1:0]   set_h_in, set_h_ff;
   logic [PAD_W-1:0]        pad_ff;
   loc_type                 loc1_ff, loc2_ff;
   logic [OUT_LINE_W-1:0]   t_ff;
   logic [OUT_LINE_W-1:0]   cube;
   logic [OUT_LINE_W-1:0]   off_ext;
   res_type                 res_in, res_ff;

   // Stage handshake.
   assign adv[NS] = out_ready;
   for (genvar k = 0; k < NS; k++) begin : g_adv
      assign adv[k] = ~vld_ff[k] | adv[k+1];
   end
   assign in_ready  = adv[0];
   assign out_valid = vld_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) begin
            vld_ff[0] <= in_valid;
         end
         for (int k = 1; k < NS; k++) begin
            if (adv[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   // Stage one: set times framelet height (4 or 14) and the band padding.
   assign set_h_in = in_data.uv ? (in_data.set_low << 2)
                                : (in_data.set_low << 4) - (in_data.set_low << 1);

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         set_h_ff <= set_h_in;
         pad_ff   <= PAD_W'(in_data.coeff) * PAD_W'(color_offset);
         loc1_ff  <= in_data;
      end
   end

   // Stage two: first line of the framelet before the base offset.
   always_ff @(posedge clock) begin
      if (adv[1]) begin
         t_ff    <= set_h_ff + OUT_LINE_W'(pad_ff);
         loc2_ff <= loc1_ff;
      end
   end

   // Stage three: optional flip, line offset and UV window.
   assign cube    = OUT_LINE_W'(loc2_ff.uv ? uv_cube_lines : vis_cube_lines);
   assign off_ext = {{(OUT_LINE_W-OFF_W){loc2_ff.line_off[OFF_W-1]}}, loc2_ff.line_off};

   always_comb begin
      res_in.dest    = loc2_ff.dest;
      res_in.band    = loc2_ff.band;
      res_in.extract = loc2_ff.uv;
      if (flip_lines) begin
         res_in.out_line = cube - t_ff + off_ext;
      end else begin
         res_in.out_line = t_ff + OUT_LINE_W'(1) + off_ext;
      end
      // A UV line narrower than the window flags an error and starts at zero.
      res_in.err   = loc2_ff.uv && (input_samples < UV_WINDOW);
      res_in.start = '0;
      if (loc2_ff.uv && !res_in.err) begin
         res_in.start = input_samples[SAMPLES_W-1:1] - UV_HALF_SPAN;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         res_ff <= res_in;
      end
   end

   assign out_data = res_ff;

endmodule

// File: bench/flr_route_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the framelet line router: tracks the register writes, predicts the
// routing of every accepted line and compares each result transaction against it.
// Depends on flr_pkg for the mode, register index and result types.
module flr_route_checker #(
   parameter int LINE_BITS = 20
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [((LINE_BITS+7)/8)*8-1:0]   req_tdata,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [39:0]                      rsp_tdata,
   input  logic [3:0]                       rsp_tuser,
   input  logic                             csr_wen,
   input  logic [flr_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [flr_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output int                               failures,
   output int                               pending,
   output int                               checked,
   output int                               narrow_hits
);
   import flr_pkg::*;

   localparam int MAX_PRINTED = 40;

   typedef struct packed {
      logic [LINE_BITS-1:0] line;
      res_type              route;
   } route_entry_type;

   // Shadow copy of the register file.
   mode_type cfg_mode;
   longint   cfg_offset;
   logic     cfg_flip;
   longint   cfg_uv_lines;
   longint   cfg_vis_lines;
   longint   cfg_samples;

   route_entry_type routes_due [$];
   int              fail_count = 0;
   int              check_count = 0;
   int              narrow_count = 0;
   int              due_count = 0;

   assign failures    = fail_count;
   assign pending     = due_count;
   assign checked     = check_count;
   assign narrow_hits = narrow_count;

   // Lines in framelet k of a set; zero past the last framelet in every mode but color.
   function automatic longint framelet_rows(input mode_type m, input int k);
      case (m)
         MODE_COLOR: return (k < 2) ? 4 : 14;
         MODE_VIS:   return (k < 5) ? 14 : 0;
         MODE_UV:    return (k < 2) ? 4 : 0;
         default:    return (k == 0) ? 14 : 0;
      endcase
   endfunction

   // Works out destination, band, output line and window for one raw line.
   function automatic res_type route_line(input longint line);
      res_type  r;
      longint   set_lines;
      longint   set_idx;
      longint   set_off;
      longint   rem;
      longint   line_off;
      longint   rows;
      longint   pad;
      longint   base;
      int       fr;
      logic     found;
      logic     uv;
      logic     color;
      set_lines = 0;
      for (int k = 0; k < 7; k++)
         set_lines += framelet_rows(cfg_mode, k);
      // Line zero sits one line ahead of the first framelet of set zero.
      if (line == 0) begin
         set_idx = 0;
         set_off = -1;
      end else begin
         set_idx = (line - 1) / set_lines;
         set_off = (line - 1) % set_lines;
      end
      // Walk the framelets until the offset falls inside one.
      rem      = set_off;
      fr       = 0;
      line_off = 0;
      found    = 1'b0;
      for (int k = 0; k < 7; k++) begin
         if (!found) begin
            rem -= framelet_rows(cfg_mode, k);
            if (rem < 0) begin
               found    = 1'b1;
               fr       = k;
               line_off = rem + framelet_rows(cfg_mode, k);
            end
         end
      end
      color = (cfg_mode == MODE_COLOR);
      rows  = framelet_rows(cfg_mode, fr);
      pad   = cfg_offset * rows * fr;
      if (color && fr > 1)
         pad -= 2 * cfg_offset * rows;
      uv     = (cfg_mode == MODE_UV) || (color && fr < 2);
      r.band = 3'(fr + 1 - ((color && fr >= 2) ? 2 : 0));
      // Odd-numbered sets feed the even streams.
      r.dest = (uv ? DEST_UV_EVEN : DEST_VIS_EVEN) + ((set_idx % 2 == 1) ? 2'd0 : 2'd1);
      base   = set_idx * (uv ? 4 : 14) + 1 + pad;
      if (cfg_flip)
         base = (uv ? cfg_uv_lines : cfg_vis_lines) - (base - 1);
      base += line_off;
      r.out_line = OUT_LINE_W'(base);
      r.extract  = uv;
      r.err      = uv && (cfg_samples < 128);
      r.start    = (uv && !r.err) ? START_W'(cfg_samples / 2 - 64) : '0;
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      fail_count++;
      if (fail_count <= MAX_PRINTED)
         $display("ERROR at %0t: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input longint want, input longint got,
                              input longint line);
      if (want != got)
         report_mismatch($sformatf("line %0d, %s: expected %0d, got %0d",
                                   line, name, want, got));
   endtask

   // Sample every channel at the rising edge; results leave before new lines enter.
   always @(posedge clock) begin
      route_entry_type want;
      route_entry_type fresh;
      if (reset) begin
         cfg_mode      = MODE_COLOR;
         cfg_offset    = 0;
         cfg_flip      = 1'b0;
         cfg_uv_lines  = 1;
         cfg_vis_lines = 1;
         cfg_samples   = 1024;
         routes_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (routes_due.size() == 0) begin
               report_mismatch($sformatf("result 0x%h/0x%h with no line outstanding",
                                         rsp_tdata, rsp_tuser));
            end else begin
               want = routes_due.pop_front();
               check_field("destination", want.route.dest, rsp_tuser[1:0], want.line);
               check_field("out_band", want.route.band, rsp_tdata[2:0], want.line);
               check_field("out_line", want.route.out_line, rsp_tdata[24:3], want.line);
               check_field("extract_middle", want.route.extract, rsp_tuser[2], want.line);
               check_field("start_sample", want.route.start, rsp_tdata[36:25], want.line);
               check_field("error", want.route.err, rsp_tuser[3], want.line);
               check_count++;
               if (want.route.err)
                  narrow_count++;
            end
         end
         if (req_tvalid && req_tready) begin
            fresh.line  = req_tdata[LINE_BITS-1:0];
            fresh.route = route_line(longint'(req_tdata[LINE_BITS-1:0]));
            routes_due.insert(routes_due.size(), fresh);
         end
         // Register writes; unused indexes change nothing.
         if (csr_wen) begin
            case (csr_addr)
               CSR_MODE:           cfg_mode      = mode_type'(csr_wdata[1:0]);
               CSR_COLOR_OFFSET:   cfg_offset    = csr_wdata[5:0];
               CSR_FLIP_LINES:     cfg_flip      = csr_wdata[0];
               CSR_UV_CUBE_LINES:  cfg_uv_lines  = csr_wdata[19:0];
               CSR_VIS_CUBE_LINES: cfg_vis_lines = csr_wdata[19:0];
               CSR_INPUT_SAMPLES:  cfg_samples   = csr_wdata[12:0];
               default: ;
            endcase
         end
      end
      due_count = routes_due.size();
   end

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps
// Top of the framelet line router bench: clock, reset, line and register stimulus,
// result back-pressure and the verdict. Depends on flr_pkg, flr_route_checker and the RTL.
module tb;
   import flr_pkg::*;

   localparam int LINE_BITS   = 20;
   localparam int REQ_W       = ((LINE_BITS + 7) / 8) * 8;
   localparam int CYCLE_LIMIT = 500000;
   localparam int HOLD_CYCLES = 80;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 110;
   localparam logic [LINE_BITS-1:0] LINE_MAX = '1;

   // Register indexes that the block does not decode.
   localparam logic [CSR_ADDR_W-1:0] CSR_UNUSED_LO = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] CSR_UNUSED_HI = 3'd7;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [39:0]           rsp_tdata;
   logic [3:0]            rsp_tuser;
   logic                  csr_wen    = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   int   failures;
   int   pending;
   int   checked;
   int   narrow_hits;
   int   cycle_count = 0;
   int   lines_sent  = 0;
   int   settings    = 0;
   logic calm        = 1'b0;
   logic hold_off_req = 1'b0;

   framelet_line_router_unit #(.LINE_BITS(LINE_BITS)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   flr_route_checker #(.LINE_BITS(LINE_BITS)) i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wen     (csr_wen),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .failures    (failures),
      .pending     (pending),
      .checked     (checked),
      .narrow_hits (narrow_hits)
   );

   // 10 ns clock.
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("framelet_line_router_unit verification failed");
         $finish;
      end
   end

   // Idle length: mostly none, sometimes short, rarely a long stretch.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 70)
         return 0;
      if (r < 95)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Raw line numbers: many near line zero, among the low lines or near the largest line, the rest anywhere.
   function automatic logic [LINE_BITS-1:0] pick_line();
      case ($urandom_range(0, 9))
         0:       return LINE_BITS'($urandom_range(0, 8));
         1, 2:    return LINE_BITS'($urandom_range(1, 400));
         3:       return LINE_MAX - LINE_BITS'($urandom_range(0, 200));
         default: return LINE_BITS'($urandom);
      endcase
   endfunction

   // Offers one line and returns at the falling edge after it was taken.
   task automatic offer_line(input logic [LINE_BITS-1:0] line);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  <= REQ_W'(line);
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      lines_sent++;
      @(negedge clock);
   endtask

   // Stops offering and waits until every routed line has come back.
   task automatic drain_routes();
      req_tvalid <= 1'b0;
      while (pending != 0)
         @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      csr_wen   <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(negedge clock);
      csr_wen <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_routing(input mode_type mode, input int offset, input logic flip,
                              input int uv_lines, input int vis_lines, input int samples);
      csr_write(CSR_MODE, CSR_DATA_W'(mode));
      csr_write(CSR_COLOR_OFFSET, CSR_DATA_W'(offset));
      csr_write(CSR_FLIP_LINES, CSR_DATA_W'(flip));
      csr_write(CSR_UV_CUBE_LINES, CSR_DATA_W'(uv_lines));
      csr_write(CSR_VIS_CUBE_LINES, CSR_DATA_W'(vis_lines));
      csr_write(CSR_INPUT_SAMPLES, CSR_DATA_W'(samples));
      settings++;
   endtask

   function automatic int pick_cube_lines();
      case ($urandom_range(0, 4))
         0:       return 0;
         1:       return 1;
         2:       return 20'hFFFFF;
         3:       return $urandom_range(1, 2000);
         default: return $urandom_range(0, 20'hFFFFF);
      endcase
   endfunction

   function automatic int pick_samples();
      case ($urandom_range(0, 7))
         0:       return 0;
         1:       return 127;
         2:       return 128;
         3:       return 4096;
         4:       return 8191;
         default: return $urandom_range(0, 8191);
      endcase
   endfunction

   // Result side: random stalls, plus one long hold-off on request.
   initial begin
      int   stall;
      logic hold_done;
      stall     = 0;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req && !hold_done) begin
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_tready <= 1'b1;
         end else if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
               stall = pick_gap();
         end
      end
   end

   // Line stimulus and register phases.
   initial begin
      int offset_pick;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // Reset settings: set boundaries, both UV framelets, first visible band.
      offer_line(20'd0);
      offer_line(20'd1);
      offer_line(20'd5);
      offer_line(20'd9);
      offer_line(20'd78);
      offer_line(20'd79);
      offer_line(LINE_MAX);
      drain_routes();

      // Color with full padding, flipped against extreme cube heights, narrow input.
      set_routing(MODE_COLOR, 63, 1'b1, 20'hFFFFF, 0, 127);
      offer_line(20'd0);
      offer_line(20'd5);
      offer_line(20'd23);
      offer_line(20'd78);
      offer_line(20'h55555);
      offer_line(20'hAAAAA);
      drain_routes();

      // Ultraviolet only, window just fits; unused indexes must change nothing.
      set_routing(MODE_UV, 1, 1'b0, 1, 1, 128);
      csr_write(CSR_UNUSED_LO, '1);
      csr_write(CSR_UNUSED_HI, '1);
      offer_line(20'd0);
      offer_line(20'd4);
      offer_line(20'd5);
      offer_line(20'd8);
      offer_line(20'd9);
      drain_routes();

      // Black and white, widest sample count the register holds.
      set_routing(MODE_BW, 63, 1'b1, 1, 20'hFFFFF, 8191);
      offer_line(20'd0);
      offer_line(20'd14);
      offer_line(20'd15);
      drain_routes();

      // Visible only, zero samples, which never matter off the UV streams.
      set_routing(MODE_VIS, 0, 1'b0, 1, 1, 0);
      offer_line(20'd0);
      offer_line(20'd70);
      offer_line(20'd71);
      offer_line(LINE_MAX);
      drain_routes();

      // Random phases, each with fresh register settings.
      for (int p = 0; p < PHASES; p++) begin
         offset_pick = $urandom_range(0, 2);
         set_routing(mode_type'($urandom_range(0, 3)),
                     (offset_pick == 0) ? 0 : (offset_pick == 1) ? 63 : $urandom_range(0, 63),
                     1'($urandom_range(0, 1)), pick_cube_lines(), pick_cube_lines(),
                     pick_samples());
         calm = (p % 3 == 1);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // Hold the results back while lines keep coming, to fill the pipeline.
            if (p == 1 && i == 30)
               hold_off_req = 1'b1;
            offer_line(pick_line());
         end
         drain_routes();
      end

      repeat (20) @(negedge clock);
      $display("Routed %0d lines under %0d register settings in all four modes.",
               lines_sent, settings);
      $display("Compared %0d results, %0d of them flagged for a narrow input line.",
               checked, narrow_hits);
      if (failures == 0 && pending == 0)
         $display("framelet_line_router_unit verification clean");
      else
         $display("framelet_line_router_unit verification failed");
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/flr_pkg.sv
rtl/core/flr_divide.sv
rtl/core/flr_locate.sv
rtl/core/flr_place.sv
rtl/core/framelet_line_router_unit.sv
bench/flr_route_checker.sv
bench/tb.sv
